// ===== hw/rtl/sot_pkg.sv =====
// package: slot kinds, command codes and slot record type for the sync object table
package sot_pkg;

  typedef enum logic [2:0] {
    KIND_FREE   = 3'd0,
    KIND_EVENT  = 3'd1,
    KIND_MUTEX  = 3'd2,
    KIND_SEM    = 3'd3,
    KIND_THREAD = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    CMD_NEW_EVENT   = 4'd0,
    CMD_NEW_MUTEX   = 4'd1,
    CMD_NEW_SEM     = 4'd2,
    CMD_NEW_THREAD  = 4'd3,
    CMD_SET         = 4'd4,
    CMD_RESET       = 4'd5,
    CMD_PULSE       = 4'd6,
    CMD_REL_MUTEX   = 4'd7,
    CMD_REL_SEM     = 4'd8,
    CMD_THREAD_EXIT = 4'd9,
    CMD_TRY_WAIT    = 4'd10,
    CMD_KNOWN       = 4'd11,
    CMD_EXIT_CODE   = 4'd12,
    CMD_CLOSE       = 4'd13,
    CMD_RSVD_E      = 4'd14,
    CMD_RSVD_F      = 4'd15
  } cmd_t;

  localparam logic [1:0] WAIT_ACQUIRED = 2'd0;
  localparam logic [1:0] WAIT_NOT_SAT  = 2'd1;
  localparam logic [1:0] WAIT_UNKNOWN  = 2'd2;

  localparam logic [15:0] DEPTH_MAX = 16'hffff;

  // one slot record as held in the table memory
  typedef struct packed {
    kind_t              kind;
    logic               sticky;
    logic               signalled;
    logic [31:0]        owner_thread;
    logic [15:0]        depth;
    logic signed [31:0] sem_count;
    logic signed [31:0] sem_max;
    logic               exited;
    logic [31:0]        exit_value;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

// ===== hw/rtl/sot_if.sv =====
// handshake channel interfaces for commands and results
interface sot_cmd_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic [31:0]        handle;
  logic [31:0]        thread_id;
  logic               flag_one;
  logic               flag_two;
  logic signed [31:0] amount;
  logic signed [31:0] limit;
  logic [31:0]        code_in;
  modport source (output valid, command, handle, thread_id, flag_one, flag_two,
                  amount, limit, code_in, input ready);
  modport sink (input valid, command, handle, thread_id, flag_one, flag_two,
                amount, limit, code_in, output ready);
endinterface

interface sot_res_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic [31:0]        new_handle;
  logic [1:0]         wait_status;
  logic signed [31:0] previous_count;
  logic [31:0]        code_out;
  modport source (output valid, ok, new_handle, wait_status, previous_count, code_out,
                  input ready);
  modport sink (input valid, ok, new_handle, wait_status, previous_count, code_out,
                output ready);
endinterface

// ===== hw/rtl/sync_object_table.sv =====
// top level: synchronization object table with read-modify-write slot memory
//
//  channel | dir | payload
//  cmd     | in  | command handle thread_id flag_one flag_two amount limit code_in
//  res     | out | ok new_handle wait_status previous_count code_out
//
// a command is accepted in idle and its slot is read at that edge; the next cycle
// modifies and writes the slot back, and the result is offered the cycle after.
// with the result taken at once a command passes through idle, exec and out; the next command
// is accepted the cycle after the result transfer.
// the lowest free slot comes from a priority encoder over a free bitmap in flip-flops.
// the bitmap clears at reset; a slot's memory record is rewritten on create,
// so reset clears control state only and no clearing pass is needed.
// a held result blocks the next command until it is transferred.
module sync_object_table #(
  parameter int          SLOT_COUNT  = 256,
  parameter logic [31:0] HANDLE_BASE = 32'h0009_0000
) (
  input logic         clk,
  input logic         rst,
  sot_cmd_if.sink     cmd,
  sot_res_if.source   res
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // latched command
  logic [3:0]         c_cmd;
  logic [31:0]        c_tid;
  logic               c_f1;
  logic               c_f2;
  logic signed [31:0] c_amount;
  logic signed [31:0] c_limit;
  logic [31:0]        c_code;
  logic               c_live;
  logic               c_create;
  logic               c_full;
  logic [IDX_W-1:0]   c_idx;

  // per-slot live map
  logic [SLOT_COUNT-1:0] used;

  // memory ports
  logic               wr_en;
  logic [IDX_W-1:0]   rd_addr;
  sot_pkg::slot_t     rd_slot;
  sot_pkg::slot_t     wr_slot;
  logic [sot_pkg::SLOT_W-1:0] rd_bits;

  sot_ram #(.WIDTH(sot_pkg::SLOT_W), .DEPTH(SLOT_COUNT)) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(c_idx),
    .wr_data(wr_slot),
    .rd_addr(rd_addr),
    .rd_data(rd_bits)
  );
  assign rd_slot = sot_pkg::slot_t'(rd_bits);

  // handle decode and free search
  logic [32:0]      h_off;
  logic             h_in;
  logic [IDX_W-1:0] h_idx;
  logic [IDX_W-1:0] free_idx;
  logic             free_any;
  logic             is_create;

  assign h_off     = {1'b0, cmd.handle} - {1'b0, HANDLE_BASE};
  assign h_in      = !h_off[32] && (h_off[31:0] < 32'(SLOT_COUNT));
  assign h_idx     = h_off[IDX_W-1:0];
  assign is_create = (cmd.command <= 4'(sot_pkg::CMD_NEW_THREAD));

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  assign rd_addr  = h_idx;
  assign cmd.ready = (state == ST_IDLE);

  // state register
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd.valid) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_OUT;
      ST_OUT:  if (res.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      c_cmd    <= cmd.command;
      c_tid    <= cmd.thread_id;
      c_f1     <= cmd.flag_one;
      c_f2     <= cmd.flag_two;
      c_amount <= cmd.amount;
      c_limit  <= cmd.limit;
      c_code   <= cmd.code_in;
      c_create <= is_create;
      c_full   <= !free_any;
      c_idx    <= is_create ? free_idx : h_idx;
      c_live   <= h_in && used[h_idx];
    end
  end

  // modify step
  sot_pkg::slot_t     s;
  logic               ok_n;
  logic [31:0]        nh_n;
  logic [1:0]         ws_n;
  logic signed [31:0] prev_n;
  logic [31:0]        code_n;
  logic               close_n;
  logic signed [32:0] sum;
  logic signed [31:0] sat_n;
  logic               sat;

  always_comb begin
    s       = rd_slot;
    wr_en   = 1'b0;
    ok_n    = 1'b0;
    nh_n    = '0;
    ws_n    = sot_pkg::WAIT_ACQUIRED;
    prev_n  = '0;
    code_n  = '0;
    close_n = 1'b0;
    sat     = 1'b0;
    sum     = {rd_slot.sem_count[31], rd_slot.sem_count} + {c_amount[31], c_amount};
    if (sum > 33'sd2147483647) sat_n = 32'sh7fffffff;
    else if (sum < -33'sd2147483648) sat_n = 32'sh80000000;
    else sat_n = sum[31:0];
    if (rd_slot.sem_max > 0 && sat_n > rd_slot.sem_max) sat_n = rd_slot.sem_max;

    if (c_create) begin
      if (!c_full) begin
        s = '0;
        s.kind = sot_pkg::kind_t'(c_cmd[2:0] + 3'd1);
        unique case (c_cmd)
          sot_pkg::CMD_NEW_EVENT: begin
            s.sticky    = c_f1;
            s.signalled = c_f2;
          end
          sot_pkg::CMD_NEW_MUTEX: if (c_f1) begin
            s.owner_thread = c_tid;
            s.depth        = 16'd1;
          end
          sot_pkg::CMD_NEW_SEM: begin
            s.sem_count = c_amount;
            s.sem_max   = c_limit;
          end
          default: s.owner_thread = c_tid;
        endcase
        wr_en = 1'b1;
        ok_n  = 1'b1;
        nh_n  = HANDLE_BASE + 32'(c_idx);
      end
    end else if (c_cmd == sot_pkg::CMD_TRY_WAIT) begin
      if (!c_live) begin
        ws_n = sot_pkg::WAIT_UNKNOWN;
      end else begin
        case (rd_slot.kind)
          sot_pkg::KIND_EVENT:  sat = rd_slot.signalled;
          sot_pkg::KIND_MUTEX:  sat = rd_slot.owner_thread == '0 ||
                                      rd_slot.owner_thread == c_tid;
          sot_pkg::KIND_SEM:    sat = rd_slot.sem_count > 0;
          sot_pkg::KIND_THREAD: sat = rd_slot.exited;
          default:              sat = 1'b0;
        endcase
        if (sat) begin
          case (rd_slot.kind)
            sot_pkg::KIND_EVENT: if (!rd_slot.sticky) s.signalled = 1'b0;
            sot_pkg::KIND_MUTEX: begin
              s.owner_thread = c_tid;
              if (rd_slot.depth != sot_pkg::DEPTH_MAX) s.depth = rd_slot.depth + 16'd1;
            end
            sot_pkg::KIND_SEM: s.sem_count = rd_slot.sem_count - 32'sd1;
            default: ;
          endcase
          wr_en = 1'b1;
          ok_n  = 1'b1;
        end else begin
          ws_n = sot_pkg::WAIT_NOT_SAT;
        end
      end
    end else if (c_live) begin
      case (c_cmd) inside
        sot_pkg::CMD_SET: if (rd_slot.kind == sot_pkg::KIND_EVENT) begin
          s.signalled = 1'b1; ok_n = 1'b1;
        end
        sot_pkg::CMD_RESET, sot_pkg::CMD_PULSE:
          if (rd_slot.kind == sot_pkg::KIND_EVENT) begin
            s.signalled = 1'b0; ok_n = 1'b1;
          end
        sot_pkg::CMD_REL_MUTEX:
          if (rd_slot.kind == sot_pkg::KIND_MUTEX && rd_slot.owner_thread == c_tid &&
              rd_slot.depth != '0) begin
            s.depth = rd_slot.depth - 16'd1;
            if (rd_slot.depth == 16'd1) s.owner_thread = '0;
            ok_n = 1'b1;
          end
        sot_pkg::CMD_REL_SEM: if (rd_slot.kind == sot_pkg::KIND_SEM) begin
          prev_n      = rd_slot.sem_count;
          s.sem_count = sat_n;
          ok_n        = 1'b1;
        end
        sot_pkg::CMD_THREAD_EXIT:
          if (rd_slot.kind == sot_pkg::KIND_THREAD && !rd_slot.exited) begin
            s.exited = 1'b1; s.exit_value = c_code; ok_n = 1'b1;
          end
        sot_pkg::CMD_KNOWN: ok_n = 1'b1;
        sot_pkg::CMD_EXIT_CODE: if (rd_slot.kind == sot_pkg::KIND_THREAD) begin
          code_n = rd_slot.exit_value; ok_n = 1'b1;
        end
        sot_pkg::CMD_CLOSE: begin
          s = '0; close_n = 1'b1; ok_n = 1'b1;
        end
        default: ;
      endcase
      wr_en = ok_n && (c_cmd != sot_pkg::CMD_KNOWN) && (c_cmd != sot_pkg::CMD_EXIT_CODE);
    end
    wr_en   = wr_en && (state == ST_EXEC);
    wr_slot = s;
  end

  // live map update
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (state == ST_EXEC) begin
      if (c_create && !c_full) used[c_idx] <= 1'b1;
      else if (close_n) used[c_idx] <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      res.ok             <= ok_n;
      res.new_handle     <= nh_n;
      res.wait_status    <= ws_n;
      res.previous_count <= prev_n;
      res.code_out       <= code_n;
    end
  end

  assign res.valid = (state == ST_OUT);

endmodule

// ===== hw/rtl/sot_ram.sv =====
// generic single-port write, single-port registered read ram
module sot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/sot_checker.sv =====
// port-level checker for the sync object table, bound to the top level
module sot_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_ok,
  input logic [31:0] res_new_handle,
  input logic [1:0]  res_wait_status
);

  // result stays until transferred
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before transfer");

  // no new command while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !cmd_ready)
    else $error("command taken while result pending");

  // accepted command yields a result after passing through the exec state
  a_latency: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> ##1 res_valid)
    else $error("result missing after command");

  // a wait failure never reports success
  a_wait_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_wait_status != sot_pkg::WAIT_ACQUIRED |-> !res_ok)
    else $error("failed wait reported ok");

  // a returned handle implies success
  a_handle_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_new_handle != 32'd0 |-> res_ok)
    else $error("handle without ok");

endmodule

bind sync_object_table sot_checker u_sot_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_ok         (res.ok),
  .res_new_handle (res.new_handle),
  .res_wait_status(res.wait_status)
);
